>>> sv/bgc_pkg.sv
// Package for the bipartite graph check: shared types.
package bgc_pkg;

  typedef struct packed {
    logic start_edge;   // accept an edge beat
    logic start_walk;   // accept a finish beat
  } bgc_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic odd_cycle;
    logic error;
  } bgc_sts_t;

endpackage

>>> sv/bgc_ram.sv
// Generic single-port RAM with registered read.
module bgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> sv/bgc_datapath.sv
// Datapath: adjacency stores, walk queue, marks, and the sequencer of memory steps.
module bgc_datapath #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bgc_pkg::bgc_cmd_t cmd,
  input  logic [10:0]       vcount,
  input  logic [10:0]       edge_a,
  input  logic [10:0]       edge_b,
  output bgc_pkg::bgc_sts_t sts
);
  localparam int SLOTS = 2 * MAX_EDGES;
  localparam int SW    = $clog2(SLOTS + 1);     // slot pointer incl. empty marker
  localparam int SA    = $clog2(SLOTS);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int QW    = $clog2(MAX_VERTICES + 1);
  localparam logic [SW-1:0] EMPTY = SW'(SLOTS);

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_E0, S_E1, S_E2, S_E3,
    S_SCAN, S_SCAN_RD, S_SCAN_CHK,
    S_DEQ, S_DEQ_WAIT, S_HEAD_RD, S_HEAD_WAIT, S_PAR_RD, S_PAR_WAIT,
    S_SLOT_RD, S_SLOT_WAIT, S_NB_RD, S_NB_WAIT, S_NB_CHK, S_DONE
  } dp_state_t;

  dp_state_t state_r;

  // list head memory
  logic          hd_we;  logic [VW-1:0] hd_ad;  logic [SW-1:0] hd_wd, hd_rd;
  // adjacency memories
  logic          sl_we;  logic [SA-1:0] sl_ad;  logic [SW-1:0] ns_wd, ns_rd;
  logic [VW-1:0] nb_wd, nb_rd;
  // visited and parity, parity packed with visited
  logic          vm_we;  logic [VW-1:0] vm_ad;  logic [1:0] vm_wd, vm_rd;
  // queue
  logic          q_we;   logic [VW-1:0] q_ad;   logic [VW-1:0] q_wd, q_rd;

  bgc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_head (
    .clk, .we(hd_we), .addr(hd_ad), .wdata(hd_wd), .rdata(hd_rd));
  bgc_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next (
    .clk, .we(sl_we), .addr(sl_ad), .wdata(ns_wd), .rdata(ns_rd));
  bgc_ram #(.WIDTH(VW), .DEPTH(SLOTS)) u_nbr (
    .clk, .we(sl_we), .addr(sl_ad), .wdata(nb_wd), .rdata(nb_rd));
  // visited marks cleared by the same pass as the head memory
  bgc_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_mark (
    .clk, .we(vm_we), .addr(vm_ad), .wdata(vm_wd), .rdata(vm_rd));
  bgc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue (
    .clk, .we(q_we), .addr(q_ad), .wdata(q_wd), .rdata(q_rd));

  logic [VW:0]   clr_r;            // clearing pass over head and mark memories
  logic          clr_done_r;
  logic [SW-1:0] used_r;
  logic          odd_r, err_r;
  logic [VW-1:0] ea_r, eb_r;
  logic [QW-1:0] qrd_r, qwr_r;
  logic [QW-1:0] start_r;
  logic [QW-1:0] n_r;
  logic [VW-1:0] u_r, w_r;
  logic          upar_r;
  logic [SW-1:0] s_r;
  logic          done_r;

  // saturated active count
  logic [QW-1:0] act_n;
  always_comb begin
    if ({5'd0, vcount} > 16'(MAX_VERTICES) && QW < 17) begin
      act_n = QW'(MAX_VERTICES);
    end else begin
      act_n = QW'(vcount);
    end
  end

  logic a_bad, b_bad;
  assign a_bad = (edge_a == 11'd0) || ({1'b0, edge_a} > 12'(act_n));
  assign b_bad = (edge_b == 11'd0) || ({1'b0, edge_b} > 12'(act_n));

  // memory port control
  always_comb begin
    hd_we = 1'b0; hd_ad = ea_r; hd_wd = used_r;
    sl_we = 1'b0; sl_ad = used_r[SA-1:0]; ns_wd = hd_rd; nb_wd = eb_r;
    vm_we = 1'b0; vm_ad = start_r[VW-1:0]; vm_wd = 2'b10;
    q_we  = 1'b0; q_ad = qwr_r[VW-1:0]; q_wd = start_r[VW-1:0];
    unique case (state_r)
      S_CLR: begin
        hd_we = 1'b1; hd_ad = clr_r[VW-1:0]; hd_wd = EMPTY;
        vm_we = 1'b1; vm_ad = clr_r[VW-1:0]; vm_wd = 2'b00;
      end
      S_E0: hd_ad = ea_r;
      S_E1: begin
        // head[a] read now; link slot to b
        sl_we = 1'b1; sl_ad = used_r[SA-1:0]; ns_wd = hd_rd; nb_wd = eb_r;
        hd_we = 1'b1; hd_ad = ea_r; hd_wd = used_r;
      end
      S_E2: hd_ad = eb_r;
      S_E3: begin
        sl_we = 1'b1; sl_ad = used_r[SA-1:0]; ns_wd = hd_rd; nb_wd = ea_r;
        hd_we = 1'b1; hd_ad = eb_r; hd_wd = used_r;
      end
      S_SCAN_RD, S_SCAN_CHK: vm_ad = start_r[VW-1:0];
      S_DEQ: q_ad = qrd_r[VW-1:0];
      S_HEAD_RD, S_HEAD_WAIT: hd_ad = u_r;
      S_PAR_RD, S_PAR_WAIT: vm_ad = u_r;
      S_SLOT_RD, S_SLOT_WAIT: sl_ad = s_r[SA-1:0];
      S_NB_RD, S_NB_WAIT, S_NB_CHK: vm_ad = w_r;
      default: ;
    endcase
    if (state_r == S_SCAN_CHK && vm_rd[1] == 1'b0) begin
      vm_we = 1'b1; vm_ad = start_r[VW-1:0]; vm_wd = 2'b10;
      q_we = (qwr_r < QW'(MAX_VERTICES)); q_ad = qwr_r[VW-1:0];
      q_wd = start_r[VW-1:0];
    end
    if (state_r == S_NB_CHK && vm_rd[1] == 1'b0) begin
      vm_we = 1'b1; vm_ad = w_r; vm_wd = {1'b1, ~upar_r};
      q_we = (qwr_r < QW'(MAX_VERTICES)); q_ad = qwr_r[VW-1:0]; q_wd = w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      clr_done_r <= 1'b0;
      used_r     <= '0;
      odd_r      <= 1'b0;
      err_r      <= 1'b0;
      qrd_r      <= '0;
      qwr_r      <= '0;
      done_r     <= 1'b0;
    end else begin
      done_r <= (state_r == S_DONE);
      unique case (state_r)
        S_CLR: begin
          if (clr_r == (VW+1)'(MAX_VERTICES - 1)) begin
            state_r <= S_IDLE;
            clr_r   <= '0;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd.start_edge) begin
            ea_r <= VW'(edge_a - 11'd1);
            eb_r <= VW'(edge_b - 11'd1);
            if (a_bad || b_bad) begin
              err_r <= 1'b1;
            end else if (edge_a == edge_b) begin
              odd_r <= 1'b1;
            end else if (32'(used_r) + 32'd2 > 32'(SLOTS)) begin
              err_r <= 1'b1;
            end else begin
              state_r <= S_E0;
            end
          end else if (cmd.start_walk) begin
            n_r     <= act_n;
            start_r <= '0;
            state_r <= S_SCAN;
          end
        end
        S_E0: state_r <= S_E1;
        S_E1: begin used_r <= used_r + 1'b1; state_r <= S_E2; end
        S_E2: state_r <= S_E3;
        S_E3: begin used_r <= used_r + 1'b1; state_r <= S_IDLE; end
        S_SCAN: begin
          if (start_r >= n_r || odd_r) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (vm_rd[1]) begin
            start_r <= start_r + 1'b1;
            state_r <= S_SCAN;
          end else begin
            if (qwr_r < QW'(MAX_VERTICES)) qwr_r <= qwr_r + 1'b1;
            state_r <= S_DEQ;
          end
        end
        S_DEQ: begin
          if (qrd_r < qwr_r && !odd_r) begin
            qrd_r   <= qrd_r + 1'b1;
            state_r <= S_DEQ_WAIT;
          end else begin
            start_r <= start_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_DEQ_WAIT: begin u_r <= q_rd; state_r <= S_HEAD_RD; end
        S_HEAD_RD: state_r <= S_HEAD_WAIT;
        S_HEAD_WAIT: begin s_r <= hd_rd; state_r <= S_PAR_RD; end
        S_PAR_RD: state_r <= S_PAR_WAIT;
        S_PAR_WAIT: begin upar_r <= vm_rd[0]; state_r <= S_SLOT_RD; end
        S_SLOT_RD: begin
          if (s_r >= EMPTY) begin
            state_r <= S_DEQ;
          end else begin
            state_r <= S_SLOT_WAIT;
          end
        end
        S_SLOT_WAIT: begin
          w_r <= nb_rd; s_r <= ns_rd; state_r <= S_NB_RD;
        end
        S_NB_RD: state_r <= S_NB_WAIT;
        S_NB_WAIT: state_r <= S_NB_CHK;
        S_NB_CHK: begin
          if (vm_rd[1] == 1'b0) begin
            if (qwr_r < QW'(MAX_VERTICES)) qwr_r <= qwr_r + 1'b1;
            state_r <= S_SLOT_RD;
          end else if (vm_rd[0] == upar_r) begin
            odd_r   <= 1'b1;
            state_r <= S_DEQ;
          end else begin
            state_r <= S_SLOT_RD;
          end
        end
        S_DONE: begin
          clr_done_r <= odd_r;
          state_r    <= S_CLR;
          used_r     <= '0;
          qrd_r      <= '0;
          qwr_r      <= '0;
          odd_r      <= 1'b0;
          err_r      <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result flags held for the beat after the walk
  logic err_hold_r;
  always_ff @(posedge clk) begin
    if (state_r == S_DONE) err_hold_r <= err_r;
  end

  assign sts.busy      = (state_r != S_IDLE);
  assign sts.done      = done_r;
  assign sts.odd_cycle = clr_done_r;
  assign sts.error     = err_hold_r;
endmodule

>>> sv/bgc_ctrl.sv
// Controller: input handshake, command issue and result register.
module bgc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_is_bipartite,
  output logic              out_load_error,
  output bgc_pkg::bgc_cmd_t cmd,
  input  bgc_pkg::bgc_sts_t sts
);
  typedef enum logic [1:0] {C_READY, C_WAIT, C_HOLD} ctrl_state_t;
  ctrl_state_t state_r;
  logic        go_r;   // registered copy of the command strobes; holds the input off

  // a finish beat is held off while an earlier result is still unread
  assign in_stall = (state_r != C_READY) || sts.busy || go_r ||
                    (in_kind && out_valid);
  assign cmd.start_edge = in_valid && !in_stall && !in_kind;
  assign cmd.start_walk = in_valid && !in_stall && in_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= C_READY;
      out_valid <= 1'b0;
      go_r      <= 1'b0;
    end else begin
      go_r <= cmd.start_edge || cmd.start_walk;
      // the result register is always empty by the time a walk ends
      if (state_r == C_HOLD) begin
        out_valid        <= 1'b1;
        out_is_bipartite <= ~sts.odd_cycle;
        out_load_error   <= sts.error;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        C_READY: if (cmd.start_walk) state_r <= C_WAIT;
        C_WAIT: begin
          if (sts.done) state_r <= C_HOLD;
        end
        C_HOLD: state_r <= C_READY;
        default: state_r <= C_READY;
      endcase
    end
  end
endmodule

>>> sv/bipartite_graph_check.sv
// Top level of the bipartite graph check.
// Edge beat: two list inserts through single-port RAMs; an edge that is dropped
// or a self-loop stores nothing.
// Finish beat: a walk that scans the active vertices, reads head and parity of
// each vertex reached and visits each stored slot (two per edge); out_valid
// rises during the clearing pass that follows, and that pass holds the input off.
// Reset (rst_n, synchronous) runs the same clearing pass before the first beat;
// vertex_count resets to 1.
module bipartite_graph_check #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [10:0] in_vertex_a,
  input  logic [10:0] in_vertex_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_bipartite,
  output logic        out_load_error
);
  logic [10:0]       vertex_count_r;
  bgc_pkg::bgc_cmd_t cmd;
  bgc_pkg::bgc_sts_t sts;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= 11'd1;
    end else if (cfg_we) begin
      vertex_count_r <= cfg_wdata;
    end
  end

  bgc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind,
    .out_valid, .out_stall, .out_is_bipartite, .out_load_error,
    .cmd, .sts);

  // datapath samples the beat fields on the accept edge
  bgc_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst_n, .cmd, .vcount(vertex_count_r),
    .edge_a(in_vertex_a), .edge_b(in_vertex_b), .sts);
endmodule

>>> tb/sv/bipartite_graph_check_checker.sv
// Checker for the bipartite graph check: predicts each verdict and compares it.
`timescale 1ns / 100ps

module bipartite_graph_check_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [10:0] in_vertex_a,
  input  logic [10:0] in_vertex_b,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_is_bipartite,
  input  logic        out_load_error,
  output int          fail_count,
  output int          verdicts_due
);

  localparam int VMAX  = 1024;
  localparam int SLOTS = 2 * 4096;
  localparam logic KIND_EDGE = 1'b0;

  typedef struct packed {
    logic bip;
    logic err;
  } verdict_t;

  verdict_t verdict_q[$];

  // graph store, same linking order as the block
  logic [10:0] vcount;
  int unsigned adj_head[VMAX];
  int unsigned adj_next[SLOTS];
  int unsigned adj_nbr[SLOTS];
  bit          seen[VMAX];
  bit          colour[VMAX];
  int unsigned bfs_q[VMAX];
  int unsigned rd_pos, wr_pos, slot_fill;
  bit          odd_cycle, load_err;

  function automatic int unsigned live_vertices();
    return (vcount > VMAX) ? VMAX : vcount;
  endfunction

  function automatic void wipe_graph();
    for (int i = 0; i < VMAX; i++) begin
      adj_head[i] = SLOTS;
      seen[i]     = 0;
      colour[i]   = 0;
    end
    rd_pos = 0; wr_pos = 0; slot_fill = 0;
    odd_cycle = 0; load_err = 0;
  endfunction

  function automatic void link(int unsigned from, int unsigned to);
    adj_nbr[slot_fill]  = to;
    adj_next[slot_fill] = adj_head[from];
    adj_head[from]      = slot_fill;
    slot_fill++;
  endfunction

  function automatic void store_edge(int unsigned a, int unsigned b);
    int unsigned n;
    n = live_vertices();
    if (a == 0 || b == 0 || a > n || b > n) load_err = 1;
    else if (a == b) odd_cycle = 1;
    else if (slot_fill + 2 > SLOTS) load_err = 1;
    else begin
      link(a - 1, b - 1);
      link(b - 1, a - 1);
    end
  endfunction

  // breadth-first colouring, stops at the first clash
  function automatic void colour_walk();
    int unsigned n, u, w, s;
    n = live_vertices();
    for (int unsigned st = 0; st < n && !odd_cycle; st++) begin
      if (seen[st]) continue;
      seen[st] = 1;
      colour[st] = 0;
      if (wr_pos < VMAX) bfs_q[wr_pos++] = st;
      while (rd_pos < wr_pos && !odd_cycle) begin
        u = bfs_q[rd_pos++];
        s = adj_head[u];
        while (s < SLOTS) begin
          w = adj_nbr[s];
          if (!seen[w]) begin
            seen[w] = 1;
            colour[w] = colour[u] ^ 1'b1;
            if (wr_pos < VMAX) bfs_q[wr_pos++] = w;
          end else if (colour[w] == colour[u]) begin
            odd_cycle = 1;
            break;
          end
          s = adj_next[s];
        end
      end
    end
  endfunction

  assign verdicts_due = verdict_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      vcount = 11'd1;
      wipe_graph();
      verdict_q.delete();
    end else begin
      if (cfg_we) vcount = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (in_kind == KIND_EDGE) store_edge(in_vertex_a, in_vertex_b);
        else begin
          colour_walk();
          want.bip = !odd_cycle;
          want.err = load_err;
          verdict_q = {verdict_q, want};
          wipe_graph();
        end
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result beat bip=%0b err=%0b", $time,
                   out_is_bipartite, out_load_error);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_is_bipartite !== want.bip) begin
            $display("%0t: is_bipartite expected %0b actual %0b", $time,
                     want.bip, out_is_bipartite);
            fail_count++;
          end
          if (out_load_error !== want.err) begin
            $display("%0t: load_error expected %0b actual %0b", $time,
                     want.err, out_load_error);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/bipartite_graph_check_tb.sv
// Testbench top for the bipartite graph check: stimulus, receiver and verdict.
`timescale 1ns / 100ps

module bipartite_graph_check_tb;

  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;
  localparam int   TARGET_BEATS = 1450;
  // clearing pass after the last result, with margin
  localparam int   SETTLE_CYCLES = 1200;
  localparam int   CYCLE_LIMIT   = 3000000;
  localparam int   HOLD_CYCLES   = 3000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [10:0] cfg_wdata;
  logic        in_valid, in_stall, in_kind;
  logic [10:0] in_vertex_a, in_vertex_b;
  logic        out_valid, out_stall, out_is_bipartite, out_load_error;

  int fail_count, verdicts_due;
  int beats_sent;
  int cur_count;     // mirror of vertex_count as last written
  bit quiet;         // no idling on either side
  bit hold_req;      // receiver: one long hold-off

  bipartite_graph_check u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_is_bipartite(out_is_bipartite), .out_load_error(out_load_error)
  );

  bipartite_graph_check_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_is_bipartite(out_is_bipartite), .out_load_error(out_load_error),
    .fail_count(fail_count), .verdicts_due(verdicts_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("bipartite_graph_check test failed");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request so the
  // block backs up and stalls its input.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // One beat: drive, hold until taken, then maybe a gap. in_stall is
  // sampled at the falling edge, where it is settled for the coming edge.
  task automatic send_beat(logic kind, logic [10:0] a, logic [10:0] b);
    bit taken;
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_vertex_a <= a;
    in_vertex_b <= b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    beats_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // lower valid, wait for every verdict, then let the clearing pass end
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[10:0];
    cur_count = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic finish_graph();
    send_beat(KIND_FINISH, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
  endtask

  // Random graph. Mostly well formed: either two-coloured by vertex number
  // parity (always bipartite) or unrestricted (odd cycles likely); a few
  // out-of-range endpoints and self-loops as noise.
  task automatic random_graph(int max_edges);
    int n, m, style, a, b;
    n = (cur_count > 1024) ? 1024 : cur_count;
    m = $urandom_range(0, max_edges);
    style = $urandom_range(0, 1);
    for (int i = 0; i < m; i++) begin
      if (n < 2 || $urandom_range(0, 19) == 0) begin
        a = $urandom_range(0, 2047);
        b = $urandom_range(0, 2047);
      end else if ($urandom_range(0, 29) == 0) begin
        a = $urandom_range(1, n);
        b = a;
      end else if (style == 0) begin
        a = 2 * $urandom_range(0, (n - 1) / 2) + 1;
        b = 2 * $urandom_range(1, n / 2);
      end else begin
        a = $urandom_range(1, n);
        b = $urandom_range(1, n);
        if (a == b) b = (a % n) + 1;
      end
      send_beat(KIND_EDGE, a[10:0], b[10:0]);
    end
    finish_graph();
  endtask

  initial begin
    int counts[8];
    int ph;
    counts = '{5, 16, 64, 2, 1024, 700, 3, 33};
    beats_sent = 0;
    quiet = 0;
    hold_req = 0;
    cur_count = 1;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_kind     <= KIND_EDGE;
    in_vertex_a <= '0;
    in_vertex_b <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset count of one, empty graph then a self-loop
    finish_graph();
    send_beat(KIND_EDGE, 11'd1, 11'd1);
    finish_graph();

    // full range, extreme endpoints, zero and beyond-range vertices
    set_count(1024);
    send_beat(KIND_EDGE, 11'd1, 11'd1024);
    send_beat(KIND_EDGE, 11'd1024, 11'd2);
    send_beat(KIND_EDGE, 11'd0, 11'd5);
    send_beat(KIND_EDGE, 11'd1025, 11'd1);
    send_beat(KIND_EDGE, 11'd2047, 11'd2047);
    finish_graph();

    // triangle
    set_count(3);
    send_beat(KIND_EDGE, 11'd1, 11'd2);
    send_beat(KIND_EDGE, 11'd2, 11'd3);
    send_beat(KIND_EDGE, 11'd3, 11'd1);
    finish_graph();

    // zero vertex count: everything out of range, walk starts nowhere
    set_count(0);
    send_beat(KIND_EDGE, 11'd1, 11'd1);
    finish_graph();

    // count lowered while loaded: the odd cycle on 3..5 is never reached
    set_count(5);
    send_beat(KIND_EDGE, 11'd4, 11'd5);
    send_beat(KIND_EDGE, 11'd5, 11'd3);
    send_beat(KIND_EDGE, 11'd3, 11'd4);
    send_beat(KIND_EDGE, 11'd1, 11'd2);
    set_count(2);
    finish_graph();

    // count above the maximum saturates
    set_count(2047);
    send_beat(KIND_EDGE, 11'd1024, 11'd1);
    finish_graph();

    // random phases
    ph = 0;
    while (beats_sent < TARGET_BEATS) begin
      set_count(counts[ph % 8]);
      if (ph == 1) hold_req = 1;   // long output hold-off under load
      if (counts[ph % 8] >= 700) repeat (3) random_graph(40);
      else repeat (20) random_graph(24);
      if (ph == 2) begin
        // sender waits for every verdict before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_due != 0) @(posedge clk);
      end
      ph++;
    end

    // last stretch with no idling
    quiet = 1;
    set_count(12);
    repeat (15) random_graph(16);

    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bipartite_graph_check test passed");
    end else begin
      $display("bipartite_graph_check test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/bgc_pkg.sv
sv/bgc_ram.sv
sv/bgc_datapath.sv
sv/bgc_ctrl.sv
sv/bipartite_graph_check.sv
tb/sv/bipartite_graph_check_checker.sv
tb/sv/bipartite_graph_check_tb.sv
